/* rtl/core/sparse_column_elimination_weights_defines.svh */
// Assertion macros for the sparse column elimination weights block.
// Used by the top level only; no other dependencies.
`ifndef SPARSE_COLUMN_ELIMINATION_WEIGHTS_DEFINES_SVH
`define SPARSE_COLUMN_ELIMINATION_WEIGHTS_DEFINES_SVH

// Assert an implication on every rising clock edge, disabled during reset.
`define SCEW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert an implication whose consequent is checked in the next cycle, disabled during reset.
`define SCEW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/scew_pkg.sv */
// Package for the sparse column elimination weights block.
// Holds shared constants and the controller/datapath command and status types.
`default_nettype none
package scew_pkg;

  localparam int unsigned MaxColumnEntriesDefault = 16;
  localparam int unsigned NodeBitsDefault         = 16;

  localparam int unsigned ValueBits = 32;
  localparam int unsigned CrowBits  = 16;
  localparam int unsigned ColBits   = 16;
  localparam int unsigned PosBits   = 32;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;    // register accepted input transaction
    logic absorb;     // update buffer / diagonal from captured item
    logic div_start;  // start reciprocal division
    logic div_step;   // one division iteration
    logic div_finish; // sign and saturate quotient into q
    logic rd_addr;    // read buffer entry at drain index
    logic mul;        // multiply read value by q
    logic load_out;   // load output register (weight or affine)
    logic affine;     // output is the affine result
    logic clear;      // column end: reset column state
  } scew_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_last;    // captured item closes the column
    logic is_diag;    // captured item is the diagonal
    logic div_done;   // division iterations complete
    logic drain_more; // drain index below buffered count
  } scew_sts_t;

endpackage
`default_nettype wire

/* rtl/core/scew_ctrl.sv */
// Controller state machine for the elimination weights block.
// Depends on scew_pkg for command and status types.
`default_nettype none
module scew_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire scew_pkg::scew_sts_t sts,
  output scew_pkg::scew_cmd_t     cmd
);
  import scew_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ABSORB, S_DIV, S_DIVEND, S_RD, S_MUL, S_OUT, S_AFF
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_take;

  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != S_IDLE);

  // Command decode
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:   cmd.capture = in_valid;
      S_ABSORB: begin
        cmd.absorb    = 1'b1;
        cmd.div_start = sts.is_diag;
      end
      S_DIV:    cmd.div_step = 1'b1;
      S_DIVEND: cmd.div_finish = 1'b1;
      S_RD:     cmd.rd_addr = sts.drain_more && !out_valid_r;
      S_MUL:    cmd.mul = 1'b1;
      S_OUT:    cmd.load_out = !out_valid_r;
      S_AFF: begin
        cmd.load_out = !out_valid_r;
        cmd.affine   = 1'b1;
        cmd.clear    = !out_valid_r;
      end
      default: cmd = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_take;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_ABSORB;
      S_ABSORB: begin
        if (sts.is_diag) state_nxt = S_DIV;
        else if (sts.is_last) state_nxt = S_RD;
        else state_nxt = S_IDLE;
      end
      S_DIV:    if (sts.div_done) state_nxt = S_DIVEND;
      S_DIVEND: state_nxt = sts.is_last ? S_RD : S_IDLE;
      S_RD: begin
        if (!sts.drain_more) state_nxt = S_AFF;
        else if (!out_valid_r) state_nxt = S_MUL;
      end
      S_MUL:    state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_AFF: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/scew_dp.sv */
// Datapath: column buffer, serial reciprocal divider, weight multiplier.
// Depends on scew_pkg; driven by scew_ctrl commands.
`default_nettype none
module scew_dp #(
  parameter int unsigned MAX_COLUMN_ENTRIES = scew_pkg::MaxColumnEntriesDefault,
  parameter int unsigned NODE_BITS          = scew_pkg::NodeBitsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire scew_pkg::scew_cmd_t cmd,
  output scew_pkg::scew_sts_t      sts,
  input  wire logic [15:0]         in_column_node,
  input  wire logic [15:0]         in_row_node,
  input  wire logic signed [16:0]  in_coarse_row,
  input  wire logic signed [31:0]  in_entry_value,
  input  wire logic                in_column_last,
  output logic                     out_is_affine,
  output logic [15:0]              out_coarse_row,
  output logic [15:0]              out_column,
  output logic [31:0]              out_entry_position,
  output logic signed [31:0]       out_result_value,
  output logic                     out_diag_error,
  output logic                     out_overflow,
  output logic                     out_last_of_run
);
  import scew_pkg::*;

  localparam int unsigned IdxBits = $clog2(MAX_COLUMN_ENTRIES);
  localparam int unsigned CntBits = $clog2(MAX_COLUMN_ENTRIES + 1);
  localparam int unsigned NbEff   = (NODE_BITS > 16) ? 16 : NODE_BITS;
  localparam logic [CntBits-1:0] MaxCnt = CntBits'(MAX_COLUMN_ENTRIES);

  // Captured input transaction
  logic [15:0]        col_r, row_r;
  logic signed [16:0] crow_r;
  logic signed [31:0] val_r;
  logic               last_r;

  // Column state
  logic [CrowBits-1:0]  row_mem [MAX_COLUMN_ENTRIES];
  logic [ValueBits-1:0] val_mem [MAX_COLUMN_ENTRIES];
  logic [CntBits-1:0]   cnt_r, idx_r;
  logic signed [31:0]   q_r;
  logic                 diag_seen_r, ovf_r;
  logic [PosBits-1:0]   pos_r;

  // Divider: 33-bit quotient of (2^32 + mag/2) / mag, restoring
  logic [32:0] dividend_r, quo_r;
  logic [32:0] rem_r;
  logic [31:0] mag_r;
  logic        neg_r;
  logic [5:0]  dcnt_r;
  logic [33:0] rem_sh;
  logic [33:0] rem_sub;

  // Drain path
  logic [CrowBits-1:0]  rd_row_r;
  logic signed [31:0]   rd_val_r;
  logic signed [63:0]   prod_r;

  logic is_diag;
  assign is_diag = (row_r[NbEff-1:0] == col_r[NbEff-1:0]);

  assign sts.is_last    = last_r;
  assign sts.is_diag    = is_diag;
  assign sts.div_done   = (dcnt_r == 6'd0);
  assign sts.drain_more = (idx_r < cnt_r);

  assign rem_sh  = {rem_r, dividend_r[32]};
  assign rem_sub = rem_sh - {2'b0, mag_r};

  // Weight rounding of -(a*q): add half, floor shift, saturate
  logic signed [64:0] p_w;
  logic signed [48:0] r_w;
  logic signed [31:0] wt_w;
  always_comb begin
    p_w = -{prod_r[63], prod_r} + 65'sd32768;
    r_w = p_w[64:16];
    if (r_w > 49'sh7FFFFFFF) wt_w = 32'sh7FFFFFFF;
    else if (r_w < -49'sh80000000) wt_w = 32'sh80000000;
    else wt_w = r_w[31:0];
  end

  // Reciprocal finish: sign and saturate quotient
  logic signed [31:0] q_fin;
  always_comb begin
    if (!neg_r) q_fin = (quo_r > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : quo_r[31:0];
    else if (quo_r >= 33'h080000000) q_fin = 32'sh80000000;
    else q_fin = -$signed(quo_r[31:0]);
  end

  // Control-state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      q_r         <= '0;
      diag_seen_r <= 1'b0;
      ovf_r       <= 1'b0;
      pos_r       <= '0;
      dcnt_r      <= '0;
    end else begin
      if (cmd.absorb && !is_diag && !crow_r[16]) begin
        if (cnt_r < MaxCnt) cnt_r <= cnt_r + 1'b1;
        else ovf_r <= 1'b1;
      end
      if (cmd.div_start) begin
        dcnt_r      <= 6'd33;
        diag_seen_r <= (val_r != 0);
      end else if (cmd.div_step && dcnt_r != 6'd0) begin
        dcnt_r <= dcnt_r - 6'd1;
      end
      if (cmd.div_finish) q_r <= (mag_r == 32'd0) ? 32'sd0 : q_fin;
      if (cmd.rd_addr) idx_r <= idx_r + 1'b1;
      if (cmd.load_out && !cmd.affine) pos_r <= pos_r + 32'd1;
      if (cmd.clear) begin
        cnt_r       <= '0;
        idx_r       <= '0;
        q_r         <= '0;
        diag_seen_r <= 1'b0;
        ovf_r       <= 1'b0;
      end
    end
  end

  // Payload registers and buffer memory
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_r  <= in_column_node;
      row_r  <= in_row_node;
      crow_r <= in_coarse_row;
      val_r  <= in_entry_value;
      last_r <= in_column_last;
    end
    if (cmd.absorb && !is_diag && !crow_r[16] && cnt_r < MaxCnt) begin
      row_mem[cnt_r[IdxBits-1:0]] <= crow_r[15:0];
      val_mem[cnt_r[IdxBits-1:0]] <= val_r;
    end
    if (cmd.div_start) begin
      neg_r      <= val_r[31];
      mag_r      <= val_r[31] ? (~val_r + 32'd1) : val_r;
      dividend_r <= 33'h100000000 +
                    {1'b0, (val_r[31] ? (~val_r + 32'd1) : val_r) >> 1};
      rem_r      <= '0;
      quo_r      <= '0;
    end else if (cmd.div_step && dcnt_r != 6'd0) begin
      dividend_r <= {dividend_r[31:0], 1'b0};
      if (!rem_sub[33]) begin
        rem_r <= rem_sub[32:0];
        quo_r <= {quo_r[31:0], 1'b1};
      end else begin
        rem_r <= rem_sh[32:0];
        quo_r <= {quo_r[31:0], 1'b0};
      end
    end
    if (cmd.rd_addr) begin
      rd_row_r <= row_mem[idx_r[IdxBits-1:0]];
      rd_val_r <= val_mem[idx_r[IdxBits-1:0]];
    end
    if (cmd.mul) prod_r <= rd_val_r * (diag_seen_r ? q_r : 32'sd0);
    if (cmd.load_out) begin
      out_is_affine      <= cmd.affine;
      out_coarse_row     <= cmd.affine ? 16'd0 : rd_row_r;
      out_column         <= col_r;
      out_entry_position <= pos_r;
      out_result_value   <= cmd.affine ? (diag_seen_r ? q_r : 32'sd0) : wt_w;
      out_diag_error     <= !diag_seen_r;
      out_overflow       <= ovf_r;
      out_last_of_run    <= cmd.affine;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sparse_column_elimination_weights.sv */
// Top level of the sparse column elimination weights block.
// Uses scew_pkg, scew_ctrl, scew_dp and the assertion macro header.
`default_nettype none
`include "sparse_column_elimination_weights_defines.svh"
// Takes one nonzero of a fine column per transaction and holds one item at
// a time. An off-diagonal item is captured and absorbed; a diagonal item is
// also run through the bit-serial reciprocal divider (one quotient bit per
// cycle, 33 bits). At column end each buffered coarse entry is drained with
// a read, a multiply and a load of the output register, and the next read
// waits for the output register to empty; the drain goes through the single
// buffer read port and the 32x32 multiplier, then the affine result follows;
// the output register holds a result until taken.
module sparse_column_elimination_weights #(
  parameter int unsigned MAX_COLUMN_ENTRIES = scew_pkg::MaxColumnEntriesDefault,
  parameter int unsigned NODE_BITS          = scew_pkg::NodeBitsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        in_column_node,
  input  wire logic [15:0]        in_row_node,
  input  wire logic signed [16:0] in_coarse_row,
  input  wire logic signed [31:0] in_entry_value,
  input  wire logic               in_column_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_is_affine,
  output logic [15:0]             out_coarse_row,
  output logic [15:0]             out_column,
  output logic [31:0]             out_entry_position,
  output logic signed [31:0]      out_result_value,
  output logic                    out_diag_error,
  output logic                    out_overflow,
  output logic                    out_last_of_run
);
  import scew_pkg::*;

  scew_cmd_t cmd;
  scew_sts_t sts;

  scew_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  scew_dp #(
    .MAX_COLUMN_ENTRIES (MAX_COLUMN_ENTRIES),
    .NODE_BITS          (NODE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_column_node     (in_column_node),
    .in_row_node        (in_row_node),
    .in_coarse_row      (in_coarse_row),
    .in_entry_value     (in_entry_value),
    .in_column_last     (in_column_last),
    .out_is_affine      (out_is_affine),
    .out_coarse_row     (out_coarse_row),
    .out_column         (out_column),
    .out_entry_position (out_entry_position),
    .out_result_value   (out_result_value),
    .out_diag_error     (out_diag_error),
    .out_overflow       (out_overflow),
    .out_last_of_run    (out_last_of_run)
  );

  // Output register is only loaded when empty
  `SCEW_ASSERT_IMPL(a_load_empty, clk, rst_n, cmd.load_out, !out_valid, "load over full output")
  // No input taken while a column drains
  `SCEW_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, cmd.mul || cmd.rd_addr, in_stall, "accept during drain")
  // Affine result always closes a run
  `SCEW_ASSERT_IMPL(a_affine_last, clk, rst_n, out_valid, out_is_affine == out_last_of_run, "affine/last mismatch")
  // A diagonal start leads into division iterations
  `SCEW_ASSERT_NEXT(a_div_follows, clk, rst_n, cmd.div_start, cmd.div_step, "division not started")

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for sparse_column_elimination_weights.
// Depends on scew_pkg and the block's top level; predicts every result itself.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_ENTRIES  = 16;
  localparam int WATCHDOG_MAX = 20000;
  localparam int DRAIN_WAIT   = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [15:0]        in_column_node = '0;
  logic [15:0]        in_row_node = '0;
  logic signed [16:0] in_coarse_row = '0;
  logic signed [31:0] in_entry_value = '0;
  logic               in_column_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_is_affine;
  logic [15:0]        out_coarse_row;
  logic [15:0]        out_column;
  logic [31:0]        out_entry_position;
  logic signed [31:0] out_result_value;
  logic               out_diag_error;
  logic               out_overflow;
  logic               out_last_of_run;

  sparse_column_elimination_weights u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_column_node, .in_row_node,
    .in_coarse_row, .in_entry_value, .in_column_last, .out_valid, .out_stall,
    .out_is_affine, .out_coarse_row, .out_column, .out_entry_position,
    .out_result_value, .out_diag_error, .out_overflow, .out_last_of_run
  );

  typedef struct packed {
    logic [15:0]        col;
    logic [15:0]        row;
    logic signed [16:0] crow;
    logic signed [31:0] val;
    logic               last;
  } nonzero_t;

  typedef struct packed {
    logic               affine;
    logic [15:0]        crow;
    logic [15:0]        col;
    logic [31:0]        pos;
    logic signed [31:0] val;
    logic               diag_err;
    logic               ovf;
    logic               last;
  } weight_t;

  // Directed row: item plus an optional hand-typed expectation of one result
  typedef struct {
    nonzero_t nz;
    bit       typed;
    weight_t  exp;
  } directed_t;

  // Predictor state
  logic [15:0]        col_rows [MAX_ENTRIES];
  logic signed [31:0] col_vals [MAX_ENTRIES];
  int                 col_count;
  logic signed [31:0] col_recip;
  bit                 col_diag;
  bit                 col_ovf;
  logic [31:0]        weight_pos;

  weight_t    pending_weights[$];
  int         errors = 0;
  int         n_results = 0;
  int         n_items = 0;
  int         phase = 0;
  int         idle_cycles = 0;
  bit         send_idle_pct, recv_idle_pct;

  function automatic logic signed [31:0] sat64(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] recip_q16(logic signed [31:0] a);
    longint unsigned mag, qm;
    if (a == 0) return 0;
    mag = (a < 0) ? longint'(-longint'(a)) : longint'(a);
    qm = ((64'd1 << 32) + mag / 2) / mag;
    if (a > 0) return sat64(longint'(qm));
    if (qm > (64'd1 << 31)) return 32'sh80000000;
    return sat64(-longint'(qm));
  endfunction

  function automatic logic signed [31:0] scaled_weight(logic signed [31:0] a,
                                                       logic signed [31:0] q);
    longint p, r;
    longint unsigned m;
    p = -(longint'(a) * longint'(q)) + 32768;
    if (p >= 0) r = p >>> 16;
    else begin
      m = -p;
      r = -longint'((m + 65535) >> 16);
    end
    return sat64(r);
  endfunction

  // Update column state for one nonzero and queue any results it closes
  task automatic predict_column(nonzero_t nz);
    weight_t w;
    logic signed [31:0] q;
    if (nz.row == nz.col) begin
      col_recip = recip_q16(nz.val);
      col_diag  = (nz.val != 0);
    end else if (nz.crow >= 0) begin
      if (col_count < MAX_ENTRIES) begin
        col_rows[col_count] = nz.crow[15:0];
        col_vals[col_count] = nz.val;
        col_count++;
      end else col_ovf = 1'b1;
    end
    if (!nz.last) return;
    q = col_diag ? col_recip : 32'sd0;
    for (int i = 0; i < col_count; i++) begin
      w = '{1'b0, col_rows[i], nz.col, weight_pos, scaled_weight(col_vals[i], q),
            !col_diag, col_ovf, 1'b0};
      pending_weights.push_back(w);
      weight_pos++;
    end
    w = '{1'b1, 16'd0, nz.col, weight_pos, q, !col_diag, col_ovf, 1'b1};
    pending_weights.push_back(w);
    col_count = 0;
    col_recip = 0;
    col_diag  = 0;
    col_ovf   = 0;
  endtask

  // Result checker, watchdog and receiver stall
  always @(posedge clk) begin
    weight_t got, want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_MAX);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (out_valid && !out_stall) begin
        got = '{out_is_affine, out_coarse_row, out_column, out_entry_position,
                out_result_value, out_diag_error, out_overflow, out_last_of_run};
        n_results++;
        if (pending_weights.size() == 0) begin
          $display("%0t unexpected result: actual %p", $time, got);
          errors++;
        end else begin
          want = pending_weights.pop_front();
          if (got !== want) begin
            $display("%0t mismatch: expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
      out_stall <= recv_idle_pct ? ($urandom_range(99) < 88) : 1'b0;
    end
  end

  // Send one transaction, holding it until accepted; valid stays high for a
  // back-to-back follower and drops while the sender idles
  task automatic send_nonzero(nonzero_t nz);
    while (send_idle_pct && $urandom_range(99) < 88) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_column_node <= nz.col;
    in_row_node    <= nz.row;
    in_coarse_row  <= nz.crow;
    in_entry_value <= nz.val;
    in_column_last <= nz.last;
    predict_column(nz);
    n_items++;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh80000000;
      1: return 32'sh7FFFFFFF;
      2: return $urandom_range(3) - 1;
      3: return $signed($urandom_range(32'h3FFFF)) - 32'sh1FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One random column: mostly well-formed with a diagonal, some broken
  task automatic send_random_column();
    nonzero_t nz;
    int len, diag_at;
    logic [15:0] col;
    col = $urandom;
    len = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
    diag_at = ($urandom_range(7) == 0) ? -1 : $urandom_range(len - 1);
    for (int i = 0; i < len; i++) begin
      nz.col  = ($urandom_range(15) == 0) ? 16'($urandom) : col;
      nz.row  = (i == diag_at) ? nz.col : 16'($urandom);
      if (nz.row == nz.col && i != diag_at) nz.row = ~nz.col;
      nz.crow = ($urandom_range(4) == 0) ? -17'sd1 - 17'($urandom_range(3))
                                         : 17'($urandom_range(65535));
      nz.val  = (i == diag_at && $urandom_range(9) == 0) ? 32'sd0 : rand_value();
      nz.last = (i == len - 1);
      send_nonzero(nz);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  directed_t directed[$];

  function automatic directed_t mk(logic [15:0] c, logic [15:0] r, int cr,
                                   logic signed [31:0] v, bit l);
    directed_t d;
    d.nz = '{c, r, 17'(cr), v, l};
    d.typed = 0;
    d.exp = '0;
    return d;
  endfunction

  initial begin
    directed_t d;
    nonzero_t nz;
    int rnd_items;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    col_count = 0; col_recip = 0; col_diag = 0; col_ovf = 0; weight_pos = 0;

    // Lone missing diagonal right after reset: q = 0 with error
    d = mk(16'd5, 16'd6, -1, 32'sd1, 1'b1);
    d.typed = 1;
    d.exp = '{1'b1, 16'd0, 16'd5, 32'd0, 32'sd0, 1'b1, 1'b0, 1'b1};
    directed.push_back(d);
    // Unit diagonal alone gives q = 1.0
    d = mk(16'hFFFF, 16'hFFFF, 0, 32'sh00010000, 1'b1);
    d.typed = 1;
    d.exp = '{1'b1, 16'd0, 16'hFFFF, 32'd0, 32'sh00010000, 1'b0, 1'b0, 1'b1};
    directed.push_back(d);
    // Zero diagonal: q = 0, error flag
    d = mk(16'd0, 16'd0, 65535, 32'sd0, 1'b1);
    d.typed = 1;
    d.exp = '{1'b1, 16'd0, 16'd0, 32'd0, 32'sd0, 1'b1, 1'b0, 1'b1};
    directed.push_back(d);
    // Extremes of value, coarse index and repeated diagonal
    directed.push_back(mk(16'd7, 16'd1, 65535, 32'sh7FFFFFFF, 1'b0));
    directed.push_back(mk(16'd7, 16'd2, 0, 32'sh80000000, 1'b0));
    directed.push_back(mk(16'd7, 16'd3, -65536, 32'sd123, 1'b0));
    directed.push_back(mk(16'd7, 16'd7, 0, 32'sd1, 1'b0));
    directed.push_back(mk(16'd7, 16'd7, 0, 32'sh80000000, 1'b0));
    directed.push_back(mk(16'd7, 16'hFFFF, 1, -32'sd1, 1'b1));
    // Tiny positive diagonal saturates q
    directed.push_back(mk(16'h8000, 16'd9, 5, 32'sh00020000, 1'b0));
    directed.push_back(mk(16'h8000, 16'h8000, 0, 32'sd1, 1'b1));
    // Last item is the diagonal, negative value
    directed.push_back(mk(16'd3, 16'd4, 100, 32'sh00008000, 1'b0));
    directed.push_back(mk(16'd3, 16'd3, 0, 32'shFFFF0000, 1'b1));
    // Buffer overflow: 18 coarse entries then diagonal
    for (int i = 0; i < 18; i++)
      directed.push_back(mk(16'd2, 16'(10 + i), i, 32'(i * 4096 - 20000), 1'b0));
    directed.push_back(mk(16'd2, 16'd2, 0, 32'sh00030000, 1'b1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (directed[i]) begin
      if (directed[i].typed) begin
        send_nonzero(directed[i].nz);
        if (pending_weights.size() != 0 &&
            pending_weights[pending_weights.size() - 1] !== directed[i].exp) begin
          $display("%0t table row %0d: expected %p actual %p", $time, i,
                   directed[i].exp, pending_weights[pending_weights.size() - 1]);
          errors++;
        end
      end else send_nonzero(directed[i].nz);
    end
    // Second overflowing column, 18 entries without a diagonal
    for (int i = 0; i < 18; i++) begin
      nz = '{16'd11, 16'(200 + i), 17'(i), 32'sh00010000, (i == 17)};
      send_nonzero(nz);
    end
    wait_drained();

    // Random phases: none, sender idle, receiver stall, both
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3);
      recv_idle_pct = (phase == 2 || phase == 3);
      rnd_items = n_items;
      while (n_items - rnd_items < 26) send_random_column();
      wait_drained();
    end
    recv_idle_pct = 0;
    wait_drained();

    $display("Run covered %0d nonzeros and %0d results over four idling phases,",
             n_items, n_results);
    $display("including zero/missing/repeated diagonals and buffer overflow.");
    if (errors == 0 && pending_weights.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
